// ===== design/egm_pkg.sv =====
// Shared types and constants for the edge gradient magnitude block.
package egm_pkg;
  localparam logic [1:0] ModeRoberts = 2'd0;
  localparam logic [1:0] ModePrewitt = 2'd1;
  localparam logic [1:0] ModeSobel   = 2'd2;
  localparam logic       RegMode     = 1'b0;
  localparam logic       RegWidth    = 1'b1;
  localparam logic       OpPixel     = 1'b0;
  localparam logic       OpFlush     = 1'b1;
  localparam logic [8:0] WidthReset  = 9'd250;
  localparam logic [7:0] MagMax      = 8'd255;
  localparam logic [16:0] SumSat     = 17'd65025;

  typedef struct packed {
    logic       load;     // capture a pixel and shift the window
    logic       compute;  // start the magnitude
    logic       zero_win; // clear window
    logic       rd;       // read line stores
  } dp_cmd_t;

  typedef struct packed {
    logic       root_done;
    logic [7:0] mag;
  } dp_sts_t;
endpackage

// ===== design/egm_if.sv =====
// Valid/ready stream interfaces for the block.
interface egm_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] pixel;
  modport source (output valid, op, pixel, input ready);
  modport sink   (input valid, op, pixel, output ready);
endinterface

interface egm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] magnitude;
  logic       last;
  logic       frame_end;
  modport source (output valid, magnitude, last, frame_end, input ready);
  modport sink   (input valid, magnitude, last, frame_end, output ready);
endinterface

interface egm_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [8:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/egm_datapath.sv =====
// Line stores, 3x3 window, kernel sums and bit-serial square root.
module egm_datapath #(
  parameter int MaxWidth = 256,
  localparam int AW = $clog2(MaxWidth)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  egm_pkg::dp_cmd_t  cmd_i,
  input  logic [AW-1:0]     col_i,
  input  logic [7:0]        pixel_i,
  input  logic [1:0]        mode_i,
  input  logic              border_i,
  output egm_pkg::dp_sts_t  sts_o
);
  logic [7:0] older_mem [MaxWidth];
  logic [7:0] prev_mem  [MaxWidth];
  logic [7:0] up2_q, up1_q;
  logic [7:0] win_q [9];
  logic [16:0] sum_q;
  logic [7:0]  root_q;
  logic [3:0]  bit_q;
  logic        busy_q;
  logic signed [11:0] gx, gy;
  logic [10:0] ax, ay;
  logic [21:0] sq;
  logic [7:0]  trial;
  logic [15:0] tsq;

  // read port: registered read, issued in the read state ahead of the load state
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      up2_q <= older_mem[col_i];
      up1_q <= prev_mem[col_i];
    end
    if (cmd_i.load) begin
      older_mem[col_i] <= up1_q;
      prev_mem[col_i]  <= pixel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (cmd_i.zero_win) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i*3]   <= win_q[i*3+1];
        win_q[i*3+1] <= win_q[i*3+2];
      end
      win_q[2] <= up2_q;
      win_q[5] <= up1_q;
      win_q[8] <= pixel_i;
    end
  end

  always_comb begin
    logic signed [11:0] wt;
    wt = (mode_i == egm_pkg::ModePrewitt) ? 12'sd1 : 12'sd2;
    if (mode_i == egm_pkg::ModeRoberts) begin
      gx = $signed({4'd0, win_q[5]}) - $signed({4'd0, win_q[4]});
      gy = $signed({4'd0, win_q[7]}) - $signed({4'd0, win_q[4]});
    end else begin
      gx = ($signed({4'd0, win_q[2]}) + wt * $signed({4'd0, win_q[5]})
            + $signed({4'd0, win_q[8]}))
         - ($signed({4'd0, win_q[0]}) + wt * $signed({4'd0, win_q[3]})
            + $signed({4'd0, win_q[6]}));
      gy = ($signed({4'd0, win_q[6]}) + wt * $signed({4'd0, win_q[7]})
            + $signed({4'd0, win_q[8]}))
         - ($signed({4'd0, win_q[0]}) + wt * $signed({4'd0, win_q[1]})
            + $signed({4'd0, win_q[2]}));
    end
    ax = gx[11] ? 11'(-gx) : 11'(gx);
    ay = gy[11] ? 11'(-gy) : 11'(gy);
    sq = 22'(ax) * 22'(ax) + 22'(ay) * 22'(ay);
    trial = root_q | (8'd1 << bit_q[2:0]);
    tsq = trial * trial;
  end

  // one result bit per cycle, most significant first; border and saturated results skip the bit loop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bit_q  <= '0;
      root_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.compute) begin
      if (border_i) begin
        root_q <= '0;
        busy_q <= 1'b0;
      end else if (sq >= 22'(egm_pkg::SumSat)) begin
        root_q <= egm_pkg::MagMax;
        busy_q <= 1'b0;
      end else begin
        root_q <= '0;
        sum_q  <= sq[16:0];
        bit_q  <= 4'd7;
        busy_q <= 1'b1;
      end
    end else if (busy_q) begin
      if (17'(tsq) <= sum_q) root_q <= trial;
      if (bit_q == 4'd0) busy_q <= 1'b0;
      else bit_q <= bit_q - 4'd1;
    end
  end

  assign sts_o.root_done = !busy_q;
  assign sts_o.mag = root_q;
endmodule

// ===== design/egm_ctrl.sv =====
// Sequencer: counters, border decisions and result emission.
module egm_ctrl #(
  parameter int MaxWidth = 256,
  localparam int AW = $clog2(MaxWidth),
  localparam int CW = $clog2(MaxWidth + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  egm_in_if.sink            in_if,
  egm_out_if.source         out_if,
  input  logic [8:0]        width_i,
  input  logic [1:0]        mode_i,
  output egm_pkg::dp_cmd_t  cmd_o,
  output logic [AW-1:0]     col_o,
  output logic [7:0]        pixel_o,
  output logic              border_o,
  input  egm_pkg::dp_sts_t  sts_i
);
  localparam logic [2:0] SIdle = 3'd0, SRead = 3'd1, SLoad = 3'd2, SComp = 3'd3,
                         SWait = 3'd4, SOut1 = 3'd5, SOut2 = 3'd6;
  logic [2:0] state_q, state_d;
  logic [CW-1:0] col_q, row_dummy;
  logic [1:0] row_q;
  logic [CW-1:0] flush_q;
  logic [CW-1:0] wl;
  logic [7:0] px_q;
  logic at_end_q, ov_q;
  logic [7:0] omag_q;
  logic olast_q, ofe_q;
  logic [8:0] wc;

  always_comb begin
    wc = width_i;
    if (wc < 9'd3) wc = 9'd3;
    if (32'(wc) > MaxWidth) wc = 9'(MaxWidth);
    wl = CW'(wc - 9'd1);
  end
  assign row_dummy = col_q;

  // a pixel may enter while a result is held; a flush needs the result register
  assign in_if.ready = (state_q == SIdle) && (!ov_q || in_if.op == egm_pkg::OpPixel);
  assign out_if.valid = ov_q;
  assign out_if.magnitude = omag_q;
  assign out_if.last = olast_q;
  assign out_if.frame_end = ofe_q;
  assign col_o = AW'(row_dummy);
  assign pixel_o = px_q;
  assign border_o = (mode_i != egm_pkg::ModeRoberts) &&
                    (row_q == 2'd1 || col_q == CW'(1));

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    unique case (state_q)
      SIdle: if (in_if.valid && in_if.ready) begin
        if (in_if.op == egm_pkg::OpFlush) begin
          cmd_o.zero_win = (flush_q >= wl);
        end else begin
          state_d = SRead;
        end
      end
      SRead: begin
        cmd_o.rd = 1'b1;
        state_d = SLoad;
      end
      SLoad: begin
        cmd_o.load = 1'b1;
        state_d = (row_q != 2'd0 && col_q != '0) ? SComp : SIdle;
      end
      SComp: begin
        cmd_o.compute = 1'b1;
        state_d = SWait;
      end
      SWait: if (sts_i.root_done) state_d = SOut1;
      SOut1: if (!ov_q) state_d = at_end_q ? SOut2 : SIdle;
      SOut2: if (!ov_q) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_if.valid && in_if.ready) px_q <= in_if.pixel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      col_q <= '0; row_q <= '0; flush_q <= '0;
      at_end_q <= 1'b0; ov_q <= 1'b0;
      omag_q <= '0; olast_q <= 1'b0; ofe_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ov_q && out_if.ready) ov_q <= 1'b0;
      unique case (state_q)
        SIdle: if (in_if.valid && in_if.ready && in_if.op == egm_pkg::OpFlush) begin
          ov_q <= 1'b1; omag_q <= '0; olast_q <= 1'b1;
          if (flush_q >= wl) begin
            ofe_q <= 1'b1; flush_q <= '0; col_q <= '0; row_q <= '0;
          end else begin
            ofe_q <= 1'b0; flush_q <= flush_q + CW'(1);
          end
        end
        SRead: at_end_q <= (col_q >= wl);
        SLoad: if (!(row_q != 2'd0 && col_q != '0)) begin
          // advance counters now when nothing is emitted
          if (at_end_q) begin
            col_q <= '0;
            if (row_q < 2'd2) row_q <= row_q + 2'd1;
          end else col_q <= col_q + CW'(1);
        end
        SOut1: if (!ov_q) begin
          ov_q <= 1'b1; omag_q <= sts_i.mag; olast_q <= !at_end_q; ofe_q <= 1'b0;
          if (!at_end_q) col_q <= col_q + CW'(1);
        end
        SOut2: if (!ov_q) begin
          ov_q <= 1'b1; omag_q <= '0; olast_q <= 1'b1; ofe_q <= 1'b0;
          col_q <= '0;
          if (row_q < 2'd2) row_q <= row_q + 2'd1;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== design/edge_gradient_magnitude.sv =====
// Top level of the edge gradient magnitude block.
// channel | dir | payload
// in_if   | in  | op, pixel
// out_if  | out | magnitude, last, frame_end
// cfg_if  | in  | index (0 mode, 1 width), data
// A pixel item that emits nothing passes only through the read and load states.
// Otherwise the bit-serial root runs (a border zero or a saturated result skips
// it) and one result, or two at a row end, is placed in the result register before the next item is taken.
// A flush waits in idle while a result is held in the output register.
// Reset is asynchronous; line stores are not cleared. The result register
// holds while out_if.ready is low and the sequencer waits.
module edge_gradient_magnitude #(
  parameter int MaxWidth = 256
) (
  input logic       clk_i,
  input logic       rst_ni,
  egm_in_if.sink    in_if,
  egm_out_if.source out_if,
  egm_cfg_if.sink   cfg_if
);
  localparam int AW = $clog2(MaxWidth);
  logic [1:0] mode_q;
  logic [8:0] width_q;
  egm_pkg::dp_cmd_t cmd;
  egm_pkg::dp_sts_t sts;
  logic [AW-1:0] col;
  logic [7:0] px;
  logic border;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= egm_pkg::ModeRoberts;
      width_q <= egm_pkg::WidthReset;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == egm_pkg::RegMode) mode_q <= cfg_if.data[1:0];
      else width_q <= cfg_if.data;
    end
  end

  egm_ctrl #(.MaxWidth(MaxWidth)) u_ctrl (
    .clk_i, .rst_ni, .in_if, .out_if, .width_i(width_q), .mode_i(mode_q),
    .cmd_o(cmd), .col_o(col), .pixel_o(px), .border_o(border), .sts_i(sts));

  egm_datapath #(.MaxWidth(MaxWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .col_i(col), .pixel_i(px),
    .mode_i(mode_q), .border_i(border), .sts_o(sts));

  a_no_dual: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load && cmd.compute)) else $error("load and compute together");
  a_fe_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.frame_end |-> out_if.last) else $error("frame end without last");
  a_rd_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd |=> cmd.load) else $error("read not followed by load");
endmodule

// ===== tb/edge_gradient_magnitude_test.sv =====
// Self-checking stream testbench for the edge gradient magnitude block.
module edge_gradient_magnitude_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LineDepth    = 256;
  localparam int WatchdogMax  = 5000;
  localparam int SettleCycles = 30;

  typedef struct packed {
    logic [7:0] magnitude;
    logic       last;
    logic       frame_end;
  } edge_result_t;

  typedef struct packed {
    logic       op;
    logic [7:0] pixel;
  } pixel_item_t;

  logic clk_i;
  logic rst_ni;

  egm_in_if  in_bus ();
  egm_out_if out_bus ();
  egm_cfg_if cfg_bus ();

  edge_gradient_magnitude dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  pixel_item_t  pending_pixels[$];
  edge_result_t expected_mags[$];

  // shadow of the block's state
  logic [7:0] older_row[LineDepth];
  logic [7:0] prev_row[LineDepth];
  logic [7:0] win[9];
  int         col_pos;
  int         rows_seen;
  int         flushes_done;
  logic [1:0] mode_reg;
  logic [8:0] width_reg;

  int  mismatches;
  int  idle_style;      // 0: receiver sparse, 1: sender sparse, 2: no random idling
  bit  hold_req;
  bit  hold_taken;
  int  hold_left;
  int  quiet_cycles;
  int  items_queued;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int root_clamped(int gx, int gy);
    int sum;
    int r;
    int t;
    sum = gx * gx + gy * gy;
    if (sum >= 65025) return 255;
    r = 0;
    for (int b = 128; b != 0; b = b >> 1) begin
      t = r | b;
      if (t * t <= sum) r = t;
    end
    return r;
  endfunction

  function automatic void predict_edges(logic op, logic [7:0] px);
    int         w;
    int         c;
    int         gx;
    int         gy;
    int         wt;
    int         mag;
    bit         at_end;
    bit         done;
    logic [7:0] u2;
    logic [7:0] u1;
    w = (width_reg < 3) ? 3 : ((width_reg > LineDepth) ? LineDepth : int'(width_reg));
    if (op == egm_pkg::OpFlush) begin
      done = (flushes_done >= w - 1);
      expected_mags.push_back('{8'd0, 1'b1, done});
      if (done) begin
        flushes_done = 0;
        col_pos = 0;
        rows_seen = 0;
        foreach (win[i]) win[i] = 8'd0;
      end else begin
        flushes_done++;
      end
      return;
    end
    c = col_pos;
    u2 = 8'd0;
    u1 = 8'd0;
    if (c < LineDepth) begin
      u2 = older_row[c];
      u1 = prev_row[c];
      older_row[c] = u1;
      prev_row[c] = px;
    end
    for (int i = 0; i < 3; i++) begin
      win[i * 3] = win[i * 3 + 1];
      win[i * 3 + 1] = win[i * 3 + 2];
    end
    win[2] = u2;
    win[5] = u1;
    win[8] = px;
    at_end = (c >= w - 1);
    if (rows_seen != 0 && c != 0) begin
      if (mode_reg == egm_pkg::ModeRoberts) begin
        mag = root_clamped(int'(win[5]) - int'(win[4]), int'(win[7]) - int'(win[4]));
      end else if (rows_seen == 1 || c == 1) begin
        mag = 0;
      end else begin
        wt = (mode_reg == egm_pkg::ModePrewitt) ? 1 : 2;
        gx = (int'(win[2]) + wt * int'(win[5]) + int'(win[8]))
           - (int'(win[0]) + wt * int'(win[3]) + int'(win[6]));
        gy = (int'(win[6]) + wt * int'(win[7]) + int'(win[8]))
           - (int'(win[0]) + wt * int'(win[1]) + int'(win[2]));
        mag = root_clamped(gx, gy);
      end
      expected_mags.push_back('{mag[7:0], ~at_end, 1'b0});
      if (at_end) expected_mags.push_back('{8'd0, 1'b1, 1'b0});
    end
    if (at_end) begin
      col_pos = 0;
      if (rows_seen < 2) rows_seen++;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // pixel feed
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.op    <= egm_pkg::OpPixel;
      in_bus.pixel <= 8'd0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (pending_pixels.size() != 0 &&
          !(idle_style == 0 && $urandom_range(99) < 34) &&
          !(idle_style == 1 && $urandom_range(99) < 81)) begin
        in_bus.valid <= 1'b1;
        {in_bus.op, in_bus.pixel} <= pending_pixels.pop_front();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_bus.valid && in_bus.ready) predict_edges(in_bus.op, in_bus.pixel);
  end

  // result side: random back-pressure plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      hold_left     <= 0;
      hold_taken    <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_left     <= 300;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= !((idle_style == 0 && $urandom_range(99) < 81) ||
                         (idle_style == 1 && $urandom_range(99) < 34));
    end
  end

  always @(posedge clk_i) begin
    edge_result_t got;
    edge_result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.magnitude, out_bus.last, out_bus.frame_end};
      if (expected_mags.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: magnitude %0d last %0b frame_end %0b",
                   got.magnitude, got.last, got.frame_end);
      end else begin
        want = expected_mags.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp mag %0d last %0b fe %0b, got mag %0d last %0b fe %0b",
                     want.magnitude, want.last, want.frame_end,
                     got.magnitude, got.last, got.frame_end);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogMax) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic idx, logic [8:0] value);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!(cfg_bus.valid && cfg_bus.ready));
    cfg_bus.valid <= 1'b0;
    if (idx == egm_pkg::RegMode) mode_reg = value[1:0];
    else width_reg = value;
  endtask

  // hold until the block has delivered everything and gone quiet
  task automatic drain();
    wait (pending_pixels.size() == 0 && !in_bus.valid && expected_mags.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic void add_item(logic op, logic [7:0] px);
    pending_pixels.push_back('{op, px});
    items_queued++;
  endfunction

  function automatic logic [7:0] pick_pixel(int style, int r, int c);
    case (style)
      0:       return ((r + c) % 2 != 0) ? 8'd255 : 8'd0;
      1:       return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
      2:       return 8'((r * 31 + c * 7) + $urandom_range(15));
      default: return 8'($urandom);
    endcase
  endfunction

  // a run of pixels, with an occasional stray flush when noisy
  function automatic void add_pixels(int count, int cols, int start, int style, bit noisy);
    for (int i = start; i < start + count; i++) begin
      if (noisy && $urandom_range(99) < 3) add_item(egm_pkg::OpFlush, 8'($urandom));
      add_item(egm_pkg::OpPixel, pick_pixel(style, i / cols, i % cols));
    end
  endfunction

  function automatic void add_flushes(int count);
    for (int i = 0; i < count; i++) add_item(egm_pkg::OpFlush, 8'($urandom));
  endfunction

  initial begin
    int         w;
    int         rows;
    int         phase;
    logic [8:0] wsel;
    in_bus.valid  = 1'b0;
    in_bus.op     = egm_pkg::OpPixel;
    in_bus.pixel  = 8'd0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = egm_pkg::RegMode;
    cfg_bus.data  = 9'd0;
    foreach (older_row[i]) older_row[i] = 8'd0;
    foreach (prev_row[i]) prev_row[i] = 8'd0;
    foreach (win[i]) win[i] = 8'd0;
    col_pos = 0;
    rows_seen = 0;
    flushes_done = 0;
    mode_reg = egm_pkg::ModeRoberts;
    width_reg = egm_pkg::WidthReset;
    mismatches = 0;
    idle_style = 0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    items_queued = 0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // saturating checkerboard, Roberts, narrowest row
    write_reg(egm_pkg::RegWidth, 9'd3);
    add_pixels(9, 3, 0, 0, 1'b0);
    add_flushes(3);
    drain();
    // early flushes before the rows are complete, then Sobel on the checkerboard
    add_pixels(4, 3, 0, 3, 1'b0);
    add_flushes(3);
    drain();
    write_reg(egm_pkg::RegMode, {7'b1111111, egm_pkg::ModeSobel});
    add_pixels(9, 3, 0, 0, 1'b0);
    add_flushes(3);
    drain();

    phase = 0;
    while (items_queued < 500) begin
      idle_style = (items_queued < 180) ? 0 : ((items_queued < 360) ? 1 : 2);
      case (phase)
        0:       wsel = 9'd0;
        1:       wsel = 9'd511;
        2:       wsel = 9'd2;
        default: wsel = 9'($urandom_range(3, 12));
      endcase
      write_reg(egm_pkg::RegMode, (phase == 3) ? 9'd3 : 9'($urandom_range(3)));
      write_reg(egm_pkg::RegWidth, wsel);
      w = (wsel < 3) ? 3 : ((wsel > LineDepth) ? LineDepth : int'(wsel));
      rows = $urandom_range(3, 7);
      if (idle_style == 2 && !hold_req) hold_req = 1'b1;
      if (w > 16) begin
        // clamped width: one full row and the start of the next, then close
        // the frame at the narrowest row
        add_pixels(w + 8, w, 0, $urandom_range(3), 1'b0);
        drain();
        write_reg(egm_pkg::RegWidth, 9'd3);
        add_flushes(3);
      end else if (phase == 4 && w >= 6) begin
        // shrink the row mid-way through, past the new last column
        add_pixels(2 * w + w - 1, w, 0, 3, 1'b0);
        drain();
        write_reg(egm_pkg::RegWidth, 9'd4);
        add_pixels(1 + 4 * 2, 4, 0, 3, 1'b0);
        add_flushes(4);
      end else begin
        add_pixels(rows * w, w, 0, $urandom_range(3), 1'b1);
        add_flushes(w);
      end
      drain();
      phase++;
    end

    drain();
    if (mismatches == 0 && expected_mags.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/egm_pkg.sv
design/egm_if.sv
design/egm_datapath.sv
design/egm_ctrl.sv
design/edge_gradient_magnitude.sv
tb/edge_gradient_magnitude_test.sv
